[rtl/core/vsau_pkg.sv]
package vsau_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    localparam logic [13:0]       PALETTE_BASE = 14'h3F00;
    localparam logic [8:0]        DOT_LAST     = 9'd340;
    localparam logic signed [9:0] LINE_PRE     = -10'sd1;
    localparam logic signed [9:0] LINE_VIS_END = 10'sd240;
    localparam logic signed [9:0] LINE_VBLANK  = 10'sd241;
    localparam logic signed [9:0] LINE_WRAP    = 10'sd261;
    localparam logic [4:0]        COARSE_Y_ROW_END = 5'd29;
    localparam logic [4:0]        COARSE_MAX       = 5'd31;
    localparam logic [8:0]        DOT_VCOPY_LO = 9'd280;
    localparam logic [8:0]        DOT_VCOPY_HI = 9'd305;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic [7:0] mem_data;
        logic [7:0] write_data;
        logic [2:0] reg_index;
        t_op        op;
    } t_item;

    typedef struct packed {
        logic [8:0]        dot;
        logic signed [9:0] scanline;
        logic              frame_wrap;
        logic              nmi_pulse;
        logic              vblank;
        logic [7:0]        mem_wdata;
        logic              mem_write;
        logic [13:0]       mem_addr;
        logic [7:0]        read_data;
    } t_result;

endpackage

[rtl/core/vsau_in_reg.sv]
module vsau_in_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [vsau_pkg::IN_DATA_W-1:0] i_data,
    input  logic                        i_take,
    output logic                        o_valid,
    output vsau_pkg::t_item             o_item
);

    logic            r_valid;
    vsau_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= vsau_pkg::t_item'(i_data[20:0]);
        end
    end

endmodule

[rtl/core/vsau_core.sv]
module vsau_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  vsau_pkg::t_item   i_item,
    output vsau_pkg::t_result o_result
);

    logic [7:0]        r_ctrl, n_ctrl;
    logic [7:0]        r_mask, n_mask;
    logic              r_vblank, n_vblank;
    logic              r_toggle, n_toggle;
    logic [7:0]        r_rbuf, n_rbuf;
    logic [2:0]        r_fine_x, n_fine_x;
    logic [14:0]       r_cur, n_cur;
    logic [14:0]       r_tmp, n_tmp;
    logic signed [9:0] r_line, n_line;
    logic [8:0]        r_dot, n_dot;

    always_comb begin
        logic [14:0] step;
        logic [14:0] v;
        logic [4:0]  cy;
        logic [8:0]  d;
        logic        rendering;
        logic        used_addr;
        logic        nmi;
        logic        frame;
        logic        mw;
        logic [7:0]  rd;

        n_ctrl   = r_ctrl;
        n_mask   = r_mask;
        n_vblank = r_vblank;
        n_toggle = r_toggle;
        n_rbuf   = r_rbuf;
        n_fine_x = r_fine_x;
        n_cur    = r_cur;
        n_tmp    = r_tmp;
        n_line   = r_line;
        n_dot    = r_dot;
        step      = r_ctrl[2] ? 15'd32 : 15'd1;
        rendering = r_mask[3] || r_mask[4];
        used_addr = 1'b0;
        nmi       = 1'b0;
        frame     = 1'b0;
        mw        = 1'b0;
        rd        = 8'd0;
        v         = r_cur;
        cy        = r_cur[9:5];
        d         = r_dot;

        case (i_item.op)
            vsau_pkg::OP_WRITE: begin
                case (i_item.reg_index)
                    vsau_pkg::REG_CTRL: begin
                        n_ctrl        = i_item.write_data;
                        n_tmp[11:10]  = i_item.write_data[1:0];
                    end
                    vsau_pkg::REG_MASK: begin
                        n_mask = i_item.write_data;
                    end
                    vsau_pkg::REG_SCROLL: begin
                        if (!r_toggle) begin
                            n_fine_x   = i_item.write_data[2:0];
                            n_tmp[4:0] = i_item.write_data[7:3];
                        end else begin
                            n_tmp[14:12] = i_item.write_data[2:0];
                            n_tmp[9:5]   = i_item.write_data[7:3];
                        end
                        n_toggle = !r_toggle;
                    end
                    vsau_pkg::REG_ADDR: begin
                        if (!r_toggle) begin
                            n_tmp[14]   = 1'b0;
                            n_tmp[13:8] = i_item.write_data[5:0];
                        end else begin
                            n_tmp[7:0] = i_item.write_data;
                            n_cur      = {r_tmp[14:8], i_item.write_data};
                        end
                        n_toggle = !r_toggle;
                    end
                    vsau_pkg::REG_DATA: begin
                        used_addr = 1'b1;
                        mw        = 1'b1;
                        n_cur     = r_cur + step;
                    end
                    default: begin
                    end
                endcase
            end
            vsau_pkg::OP_READ: begin
                case (i_item.reg_index)
                    vsau_pkg::REG_STATUS: begin
                        rd       = {r_vblank, 2'b00, r_rbuf[4:0]};
                        n_vblank = 1'b0;
                        n_toggle = 1'b0;
                    end
                    vsau_pkg::REG_DATA: begin
                        used_addr = 1'b1;
                        n_rbuf    = i_item.mem_data;
                        rd        = (r_cur[13:0] >= vsau_pkg::PALETTE_BASE) ?
                                    i_item.mem_data : r_rbuf;
                        n_cur     = r_cur + step;
                    end
                    default: begin
                    end
                endcase
            end
            vsau_pkg::OP_TICK: begin
                if (r_line >= vsau_pkg::LINE_PRE && r_line < vsau_pkg::LINE_VIS_END) begin
                    if (r_line == 10'sd0 && r_dot == 9'd0) begin
                        d = 9'd1;
                    end else if (r_line == vsau_pkg::LINE_PRE && r_dot == 9'd1) begin
                        n_vblank = 1'b0;
                    end else if (((r_dot >= 9'd2 && r_dot < 9'd258) ||
                                  (r_dot >= 9'd321 && r_dot < 9'd338)) &&
                                 r_dot[2:0] == 3'd0 && rendering) begin
                        if (v[4:0] == vsau_pkg::COARSE_MAX) begin
                            v[4:0] = 5'd0;
                            v[10]  = !v[10];
                        end else begin
                            v[4:0] = v[4:0] + 5'd1;
                        end
                    end
                    if (d == 9'd256) begin
                        if (rendering) begin
                            if (v[14:12] != 3'd7) begin
                                v[14:12] = v[14:12] + 3'd1;
                            end else begin
                                v[14:12] = 3'd0;
                                cy       = v[9:5];
                                if (cy == vsau_pkg::COARSE_Y_ROW_END) begin
                                    cy    = 5'd0;
                                    v[11] = !v[11];
                                end else if (cy == vsau_pkg::COARSE_MAX) begin
                                    cy = 5'd0;
                                end else begin
                                    cy = cy + 5'd1;
                                end
                                v[9:5] = cy;
                            end
                        end
                    end else if (d == 9'd257) begin
                        if (rendering) begin
                            v[10]  = r_tmp[10];
                            v[4:0] = r_tmp[4:0];
                        end
                    end
                    if (r_line == vsau_pkg::LINE_PRE && d >= vsau_pkg::DOT_VCOPY_LO &&
                        d < vsau_pkg::DOT_VCOPY_HI && rendering) begin
                        v[14:11] = r_tmp[14:11];
                        v[9:5]   = r_tmp[9:5];
                    end
                end
                n_cur = v;
                if (r_line == vsau_pkg::LINE_VBLANK && d == 9'd1) begin
                    n_vblank = 1'b1;
                    nmi      = r_ctrl[7];
                end
                if (d == vsau_pkg::DOT_LAST) begin
                    n_dot  = 9'd0;
                    n_line = r_line + 10'sd1;
                    if (n_line == vsau_pkg::LINE_WRAP) begin
                        n_line = vsau_pkg::LINE_PRE;
                        frame  = 1'b1;
                    end
                end else begin
                    n_dot = d + 9'd1;
                end
            end
            default: begin
            end
        endcase

        o_result.read_data  = rd;
        o_result.mem_addr   = used_addr ? r_cur[13:0] : n_cur[13:0];
        o_result.mem_write  = mw;
        o_result.mem_wdata  = mw ? i_item.write_data : 8'd0;
        o_result.vblank     = n_vblank;
        o_result.nmi_pulse  = nmi;
        o_result.frame_wrap = frame;
        o_result.scanline   = n_line;
        o_result.dot        = n_dot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl   <= 8'd0;
            r_mask   <= 8'd0;
            r_vblank <= 1'b0;
            r_toggle <= 1'b0;
            r_rbuf   <= 8'd0;
            r_fine_x <= 3'd0;
            r_cur    <= 15'd0;
            r_tmp    <= 15'd0;
            r_line   <= 10'sd0;
            r_dot    <= 9'd0;
        end else if (i_fire) begin
            r_ctrl   <= n_ctrl;
            r_mask   <= n_mask;
            r_vblank <= n_vblank;
            r_toggle <= n_toggle;
            r_rbuf   <= n_rbuf;
            r_fine_x <= n_fine_x;
            r_cur    <= n_cur;
            r_tmp    <= n_tmp;
            r_line   <= n_line;
            r_dot    <= n_dot;
        end
    end

endmodule

[rtl/core/vsau_out_reg.sv]
module vsau_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  vsau_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output vsau_pkg::t_result o_result
);

    logic              r_valid;
    vsau_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

[rtl/core/video_scroll_address_unit.sv]
// Picture unit register port and dot timer with the current/temporary scroll
// address scheme. Each request (register write, register read or one dot tick)
// is captured in an input register, resolved in one pass against the unit state
// and held in an output register; one request per clock is sustained while the
// output side is ready. A data register read expects the video memory byte at the
// current address with the request. Results carry the memory address and strobe,
// vblank, NMI and frame strobes, and the scanline and dot after the request.
module video_scroll_address_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], reg_index[4:2], write_data[12:5], mem_data[20:13], zeros above.
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], mem_addr[21:8], mem_write[22], mem_wdata[30:23],
    // vblank[31], nmi_pulse[32], frame_wrap[33], scanline[43:34], dot[52:44].
    output logic [55:0] m_axis_tdata
);

    logic              in_valid;
    logic              out_free;
    logic              fire;
    vsau_pkg::t_item   item;
    vsau_pkg::t_result result;
    vsau_pkg::t_result out_result;

    assign fire = in_valid && out_free;

    vsau_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_take  (fire),
        .o_valid (in_valid),
        .o_item  (item)
    );

    vsau_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (item),
        .o_result (result)
    );

    vsau_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (result),
        .i_ready  (m_axis_tready),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result)
    );

    assign m_axis_tdata = {3'b000, out_result};

    a_nmi_in_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_result.nmi_pulse) |-> out_result.vblank)
        else $error("NMI pulse without vblank");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_result.frame_wrap) |->
        (out_result.scanline == vsau_pkg::LINE_PRE && out_result.dot == 9'd0))
        else $error("frame strobe away from line wrap");

    a_write_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_result.mem_write) |-> (out_result.read_data == 8'd0 &&
        !out_result.nmi_pulse && !out_result.frame_wrap))
        else $error("memory write mixed with read or tick result");

    a_dot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (out_result.dot <= vsau_pkg::DOT_LAST))
        else $error("dot counter out of range");

endmodule

[bench/vsau_checker.sv]
`timescale 1ns / 100ps

module vsau_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    // op[1:0], reg_index[4:2], write_data[12:5], mem_data[20:13], zeros above.
    input  logic [23:0] i_req_data,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    // read_data[7:0], mem_addr[21:8], mem_write[22], mem_wdata[30:23],
    // vblank[31], nmi_pulse[32], frame_wrap[33], scanline[43:34], dot[52:44].
    input  logic [55:0] i_res_data,
    output int          o_pending,
    output int          o_checked,
    output int          o_frames,
    output int          o_fail_count
);

    logic [7:0]  ctrl_q;
    logic [7:0]  mask_q;
    logic [7:0]  rbuf_q;
    logic        vbl_q;
    logic        toggle_q;
    logic [2:0]  fine_x_q;
    logic [14:0] v_q;
    logic [14:0] t_q;
    int          line_q;
    int          dot_q;

    vsau_pkg::t_result due_results[$];

    task automatic clear_state();
        ctrl_q   = '0;
        mask_q   = '0;
        rbuf_q   = '0;
        vbl_q    = 1'b0;
        toggle_q = 1'b0;
        fine_x_q = '0;
        v_q      = '0;
        t_q      = '0;
        line_q   = 0;
        dot_q    = 0;
    endtask

    task automatic coarse_x_step();
        if (v_q[4:0] == 5'd31) begin
            v_q[4:0] = '0;
            v_q[10]  = ~v_q[10];
        end else begin
            v_q = v_q + 15'd1;
        end
    endtask

    task automatic fine_y_step();
        if (v_q[14:12] != 3'd7) begin
            v_q[14:12] = v_q[14:12] + 3'd1;
        end else begin
            v_q[14:12] = '0;
            if (v_q[9:5] == 5'd29) begin
                v_q[9:5] = '0;
                v_q[11]  = ~v_q[11];
            end else if (v_q[9:5] == 5'd31) begin
                v_q[9:5] = '0;
            end else begin
                v_q[9:5] = v_q[9:5] + 5'd1;
            end
        end
    endtask

    task automatic advance_dot(output logic nmi, output logic frame);
        logic rendering;
        nmi = 1'b0;
        frame = 1'b0;
        rendering = mask_q[3] | mask_q[4];
        if (line_q >= -1 && line_q < 240) begin
            if (line_q == 0 && dot_q == 0) begin
                dot_q = 1;
            end else if (line_q == -1 && dot_q == 1) begin
                vbl_q = 1'b0;
            end else if (((dot_q >= 2 && dot_q < 258) || (dot_q >= 321 && dot_q < 338)) &&
                         (dot_q % 8) == 0 && rendering) begin
                coarse_x_step();
            end
            if (dot_q == 256) begin
                if (rendering) fine_y_step();
            end else if (dot_q == 257) begin
                if (rendering) begin
                    v_q[10]  = t_q[10];
                    v_q[4:0] = t_q[4:0];
                end
            end
            if (line_q == -1 && dot_q >= 280 && dot_q < 305 && rendering) begin
                v_q[14:11] = t_q[14:11];
                v_q[9:5]   = t_q[9:5];
            end
        end
        if (line_q == 241 && dot_q == 1) begin
            vbl_q = 1'b1;
            if (ctrl_q[7]) nmi = 1'b1;
        end
        dot_q++;
        if (dot_q >= 341) begin
            dot_q = 0;
            line_q++;
            if (line_q >= 261) begin
                line_q = -1;
                frame = 1'b1;
            end
        end
    endtask

    task automatic next_result(input vsau_pkg::t_item req, output vsau_pkg::t_result res);
        logic [14:0] acc_addr;
        logic        acc_used;
        logic [7:0]  rd;
        logic        mw;
        logic        nmi;
        logic        frame;
        logic [14:0] incr;
        acc_addr = '0;
        acc_used = 1'b0;
        rd = '0;
        mw = 1'b0;
        nmi = 1'b0;
        frame = 1'b0;
        incr = ctrl_q[2] ? 15'd32 : 15'd1;
        case (req.op)
            vsau_pkg::OP_WRITE: begin
                case (req.reg_index)
                    vsau_pkg::REG_CTRL: begin
                        ctrl_q = req.write_data;
                        t_q[11:10] = req.write_data[1:0];
                    end
                    vsau_pkg::REG_MASK: mask_q = req.write_data;
                    vsau_pkg::REG_SCROLL: begin
                        if (!toggle_q) begin
                            fine_x_q = req.write_data[2:0];
                            t_q[4:0] = req.write_data[7:3];
                            toggle_q = 1'b1;
                        end else begin
                            t_q[14:12] = req.write_data[2:0];
                            t_q[9:5]   = req.write_data[7:3];
                            toggle_q = 1'b0;
                        end
                    end
                    vsau_pkg::REG_ADDR: begin
                        if (!toggle_q) begin
                            t_q[14]   = 1'b0;
                            t_q[13:8] = req.write_data[5:0];
                            toggle_q = 1'b1;
                        end else begin
                            t_q[7:0] = req.write_data;
                            v_q = t_q;
                            toggle_q = 1'b0;
                        end
                    end
                    vsau_pkg::REG_DATA: begin
                        acc_addr = v_q;
                        acc_used = 1'b1;
                        mw = 1'b1;
                        v_q = v_q + incr;
                    end
                    default: ;
                endcase
            end
            vsau_pkg::OP_READ: begin
                if (req.reg_index == vsau_pkg::REG_STATUS) begin
                    rd = {vbl_q, 2'b00, rbuf_q[4:0]};
                    vbl_q = 1'b0;
                    toggle_q = 1'b0;
                end else if (req.reg_index == vsau_pkg::REG_DATA) begin
                    acc_addr = v_q;
                    acc_used = 1'b1;
                    rd = rbuf_q;
                    rbuf_q = req.mem_data;
                    if (v_q[13:0] >= vsau_pkg::PALETTE_BASE) rd = req.mem_data;
                    v_q = v_q + incr;
                end
            end
            vsau_pkg::OP_TICK: advance_dot(nmi, frame);
            default: ;
        endcase
        res.read_data  = rd;
        res.mem_addr   = acc_used ? acc_addr[13:0] : v_q[13:0];
        res.mem_write  = mw;
        res.mem_wdata  = mw ? req.write_data : 8'h00;
        res.vblank     = vbl_q;
        res.nmi_pulse  = nmi;
        res.frame_wrap = frame;
        res.scanline   = line_q[9:0];
        res.dot        = dot_q[8:0];
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic compare_result(input vsau_pkg::t_result want,
                                  input vsau_pkg::t_result got);
        check_field("read_data", want.read_data, got.read_data);
        check_field("mem_addr", want.mem_addr, got.mem_addr);
        check_field("mem_write", want.mem_write, got.mem_write);
        check_field("mem_wdata", want.mem_wdata, got.mem_wdata);
        check_field("vblank", want.vblank, got.vblank);
        check_field("nmi_pulse", want.nmi_pulse, got.nmi_pulse);
        check_field("frame_wrap", want.frame_wrap, got.frame_wrap);
        check_field("scanline", want.scanline, got.scanline);
        check_field("dot", want.dot, got.dot);
    endtask

    always @(posedge i_clk) begin : monitor
        vsau_pkg::t_item   req;
        vsau_pkg::t_result want;
        vsau_pkg::t_result got;
        if (!i_rst_n) begin
            clear_state();
            due_results.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                req = vsau_pkg::t_item'(i_req_data[$bits(vsau_pkg::t_item)-1:0]);
                next_result(req, want);
                due_results.push_back(want);
            end
            if (i_res_valid && i_res_ready) begin
                got = vsau_pkg::t_result'(i_res_data[$bits(vsau_pkg::t_result)-1:0]);
                if (due_results.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    compare_result(want, got);
                    o_checked++;
                    if (want.frame_wrap) o_frames++;
                end
            end
        end
        o_pending = due_results.size();
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam int SWEEP_TICKS = 150;
    localparam int HOLD_CYCLES = 64;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        sink_hold = 1'b0;
    logic        hold_req = 1'b0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          sent_count = 0;
    int          tick_count = 0;
    int          pending;
    int          checked;
    int          frames;
    int          fail_count;

    always #2 clk = ~clk;

    video_scroll_address_unit u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    vsau_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (s_tvalid),
        .i_req_ready  (s_tready),
        .i_req_data   (s_tdata),
        .i_res_valid  (m_tvalid),
        .i_res_ready  (m_tready),
        .i_res_data   (m_tdata),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_frames     (frames),
        .o_fail_count (fail_count)
    );

    always @(posedge clk) begin
        m_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
    end

    // The output side is held off for a fixed stretch while requests keep coming.
    initial begin
        wait (hold_req);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    initial begin
        #10_000_000;
        $display("video_scroll_address_unit regression: fail");
        $finish;
    end

    function automatic vsau_pkg::t_item mk(input vsau_pkg::t_op op, input logic [2:0] idx,
                                           input logic [7:0] wd, input logic [7:0] md);
        vsau_pkg::t_item it;
        it.op = op;
        it.reg_index = idx;
        it.write_data = wd;
        it.mem_data = md;
        return it;
    endfunction

    function automatic vsau_pkg::t_item rand_item();
        int pick;
        pick = $urandom_range(99);
        return mk(pick < 35 ? vsau_pkg::OP_TICK : pick < 70 ? vsau_pkg::OP_WRITE :
                  pick < 95 ? vsau_pkg::OP_READ : vsau_pkg::OP_NONE,
                  3'($urandom_range(7)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    endfunction

    function automatic bit is_ignored(input vsau_pkg::t_item it);
        if (it.op == vsau_pkg::OP_NONE) return 1'b1;
        if (it.op == vsau_pkg::OP_WRITE)
            return it.reg_index == vsau_pkg::REG_STATUS || it.reg_index == REG_OAM_ADDR ||
                   it.reg_index == REG_OAM_DATA;
        if (it.op == vsau_pkg::OP_READ)
            return it.reg_index != vsau_pkg::REG_STATUS &&
                   it.reg_index != vsau_pkg::REG_DATA;
        return 1'b0;
    endfunction

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct <= 0;  end
            1: begin src_idle_pct = 46; sink_stall_pct <= 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct <= 46; end
            default: begin src_idle_pct = 23; sink_stall_pct <= 23; end
        endcase
    endtask

    task automatic send_item(input vsau_pkg::t_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, it};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_count++;
        if (it.op == vsau_pkg::OP_TICK) tick_count++;
    endtask

    task automatic send_pair(input logic [2:0] idx);
        send_item(mk(vsau_pkg::OP_WRITE, idx, 8'($urandom_range(255)),
                     8'($urandom_range(255))));
        send_item(mk(vsau_pkg::OP_WRITE, idx, 8'($urandom_range(255)),
                     8'($urandom_range(255))));
    endtask

    task automatic send_data_access();
        send_item(mk($urandom_range(1) ? vsau_pkg::OP_READ : vsau_pkg::OP_WRITE,
                     vsau_pkg::REG_DATA, 8'($urandom_range(255)), 8'($urandom_range(255))));
    endtask

    task automatic random_traffic(input int goal);
        int              done_cnt;
        int              kind;
        int              n;
        vsau_pkg::t_item it;
        done_cnt = 0;
        while (done_cnt < goal) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
                send_pair(vsau_pkg::REG_ADDR);
                n = $urandom_range(4, 1);
                repeat (n) send_data_access();
                done_cnt += 2 + n;
            end else if (kind < 45) begin
                send_pair(vsau_pkg::REG_SCROLL);
                done_cnt += 2;
            end else if (kind < 55) begin
                n = $urandom_range(40, 5);
                repeat (n) send_item(mk(vsau_pkg::OP_TICK, 3'($urandom_range(7)),
                                        8'($urandom_range(255)), 8'($urandom_range(255))));
                done_cnt += n;
            end else begin
                it = rand_item();
                send_item(it);
                if (!is_ignored(it)) done_cnt++;
            end
        end
    endtask

    // Occasional bus traffic during the frame sweep; the control byte is left alone.
    task automatic frame_traffic();
        logic [7:0] mask;
        case ($urandom_range(4))
            0: begin
                mask = 8'($urandom_range(255));
                if ($urandom_range(3) != 0) mask[3] = 1'b1;
                send_item(mk(vsau_pkg::OP_WRITE, vsau_pkg::REG_MASK, mask,
                             8'($urandom_range(255))));
            end
            1: send_pair(vsau_pkg::REG_ADDR);
            2: send_pair(vsau_pkg::REG_SCROLL);
            3: send_item(mk(vsau_pkg::OP_READ, vsau_pkg::REG_STATUS, 8'($urandom_range(255)),
                            8'($urandom_range(255))));
            default: send_data_access();
        endcase
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_item(mk(vsau_pkg::OP_TICK, 3'd0, 8'h00, 8'h00));
        send_item(mk(vsau_pkg::OP_WRITE, vsau_pkg::REG_CTRL, 8'h03, 8'h00));
        send_item(mk(vsau_pkg::OP_WRITE, vsau_pkg::REG_MASK, 8'hFF, 8'h00));
        send_item(mk(vsau_pkg::OP_WRITE, vsau_pkg::REG_SCROLL, 8'hFF, 8'h00));
        send_item(mk(vsau_pkg::OP_WRITE, vsau_pkg::REG_SCROLL, 8'hFF, 8'h00));
        send_item(mk(vsau_pkg::OP_READ, vsau_pkg::REG_STATUS, 8'h00, 8'h00));
        send_item(mk(vsau_pkg::OP_WRITE, vsau_pkg::REG_ADDR, 8'hFF, 8'h00));
        send_item(mk(vsau_pkg::OP_WRITE, vsau_pkg::REG_ADDR, 8'h00, 8'h00));
        send_item(mk(vsau_pkg::OP_READ, vsau_pkg::REG_DATA, 8'h00, 8'hA5));
        send_item(mk(vsau_pkg::OP_WRITE, vsau_pkg::REG_ADDR, 8'h3F, 8'h00));
        send_item(mk(vsau_pkg::OP_WRITE, vsau_pkg::REG_ADDR, 8'hFF, 8'h00));
        send_item(mk(vsau_pkg::OP_READ, vsau_pkg::REG_DATA, 8'hFF, 8'h5A));
        send_item(mk(vsau_pkg::OP_READ, vsau_pkg::REG_DATA, 8'h00, 8'hFF));
        send_item(mk(vsau_pkg::OP_WRITE, vsau_pkg::REG_CTRL, 8'h04, 8'h00));
        send_item(mk(vsau_pkg::OP_WRITE, vsau_pkg::REG_DATA, 8'hFF, 8'h00));
        send_item(mk(vsau_pkg::OP_WRITE, vsau_pkg::REG_DATA, 8'h00, 8'hFF));
        send_item(mk(vsau_pkg::OP_READ, vsau_pkg::REG_DATA, 8'h00, 8'h00));
        send_item(mk(vsau_pkg::OP_WRITE, vsau_pkg::REG_STATUS, 8'hFF, 8'hFF));
        send_item(mk(vsau_pkg::OP_WRITE, REG_OAM_ADDR, 8'hFF, 8'hFF));
        send_item(mk(vsau_pkg::OP_WRITE, REG_OAM_DATA, 8'hFF, 8'hFF));
        send_item(mk(vsau_pkg::OP_READ, vsau_pkg::REG_CTRL, 8'hFF, 8'hFF));
        send_item(mk(vsau_pkg::OP_READ, vsau_pkg::REG_MASK, 8'hFF, 8'hFF));
        send_item(mk(vsau_pkg::OP_READ, REG_OAM_ADDR, 8'hFF, 8'hFF));
        send_item(mk(vsau_pkg::OP_READ, REG_OAM_DATA, 8'hFF, 8'hFF));
        send_item(mk(vsau_pkg::OP_READ, vsau_pkg::REG_SCROLL, 8'hFF, 8'hFF));
        send_item(mk(vsau_pkg::OP_READ, vsau_pkg::REG_ADDR, 8'hFF, 8'hFF));
        send_item(mk(vsau_pkg::OP_NONE, vsau_pkg::REG_DATA, 8'hFF, 8'hFF));

        for (int mode = 0; mode < 4; mode++) begin
            set_idling(mode);
            random_traffic(150);
        end

        set_idling(0);
        hold_req <= 1'b1;
        repeat (100) send_item(rand_item());

        send_item(mk(vsau_pkg::OP_WRITE, vsau_pkg::REG_CTRL,
                     8'h80 | 8'($urandom_range(127)), 8'h00));
        send_item(mk(vsau_pkg::OP_WRITE, vsau_pkg::REG_MASK, 8'h18, 8'h00));
        for (int n = 0; n < SWEEP_TICKS; n++) begin
            if (n % 40 == 0) set_idling(n / 40);
            if (n == 100)
                send_item(mk(vsau_pkg::OP_WRITE, vsau_pkg::REG_CTRL,
                             8'($urandom_range(127)), 8'h00));
            if ($urandom_range(19) == 0) frame_traffic();
            send_item(mk(vsau_pkg::OP_TICK, 3'($urandom_range(7)), 8'($urandom_range(255)),
                         8'($urandom_range(255))));
        end

        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        @(negedge clk);

        $display("Sent %0d requests (%0d dot ticks), compared %0d results, %0d frames wrapped.",
                 sent_count, tick_count, checked, frames);
        $display("Covered register writes and reads, palette addresses, a long output stall,");
        $display("and the opening scanlines of dot timing with rendering enabled.");
        if (fail_count == 0) begin
            $display("video_scroll_address_unit regression: pass");
        end else begin
            $display("video_scroll_address_unit regression: fail");
        end
        $finish;
    end

endmodule
